@@ rtl/packed_decimal_to_text_defines.svh @@
// assertion macros for the packed decimal to text formatter
// used by rtl/packed_decimal_to_text.sv, expects clock and reset in scope
`ifndef PACKED_DECIMAL_TO_TEXT_DEFINES_SVH
`define PACKED_DECIMAL_TO_TEXT_DEFINES_SVH
`ifndef SYNTH
`define PDT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define PDT_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define PDT_ASSERT(lbl, prop, msg)
`define PDT_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/pdt_pkg.sv @@
// shared types and constants for the packed decimal to text formatter
// no dependencies, used by every module of the block
`timescale 1ns / 1ps
package pdt_pkg;

   localparam int MAX_FIELD_BYTES = 16;
   localparam int CHAIN_CELLS     = 2 * MAX_FIELD_BYTES;
   localparam int DIGIT_IDX_W     = $clog2(CHAIN_CELLS);
   localparam int BYTE_IDX_W      = (MAX_FIELD_BYTES > 1) ? $clog2(MAX_FIELD_BYTES) : 1;
   localparam int DIGIT_W         = 4;
   localparam int FB_W            = 5;

   localparam logic [7:0] BYTE_ZERO         = 8'h00;
   localparam logic [7:0] BYTE_EBCDIC_BLANK = 8'h40;
   localparam logic [7:0] BYTE_ASCII_BLANK  = 8'h20;
   localparam logic [7:0] CHAR_ZERO         = 8'h30;
   localparam logic [7:0] CHAR_MINUS        = 8'h2D;
   localparam logic [7:0] SYMBOL_RESET      = 8'd46;
   localparam logic [3:0] SIGN_MINUS        = 4'hD;
   localparam logic [3:0] SIGN_MINUS_ALT    = 4'hB;
   localparam logic [3:0] DIGIT_MAX         = 4'd9;

   typedef enum logic [1:0] {
      CSR_FIELD_BYTES    = 2'd0,
      CSR_SCALE          = 2'd1,
      CSR_RAW_MODE       = 2'd2,
      CSR_DECIMAL_SYMBOL = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_TEXT    = 2'd0,
      STATUS_NULL    = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CH_HOLD   = 2'd0,
      CH_SHIFT1 = 2'd1,
      CH_SHIFT2 = 2'd2
   } chain_mode_type;

   typedef enum logic [2:0] {
      S_LOAD,
      S_START,
      S_STATUS,
      S_SIGN,
      S_ZERO,
      S_INT,
      S_SYM,
      S_FRAC
   } state_type;

   typedef struct packed {
      chain_mode_type           mode;
      logic [DIGIT_W-1:0]       hi;
      logic [DIGIT_W-1:0]       lo;
      logic [DIGIT_IDX_W-1:0]   head_sel;
   } chain_ctrl_type;

endpackage

@@ rtl/pdt_cell.sv @@
// one digit cell of the shift chain: holds a nibble, takes its neighbor's
// nibble or the one two places down; depends on pdt_pkg
`timescale 1ns / 1ps
module pdt_cell (
   input  logic                          clock,
   input  pdt_pkg::chain_mode_type       mode,
   input  logic [pdt_pkg::DIGIT_W-1:0]   near_in,
   input  logic [pdt_pkg::DIGIT_W-1:0]   far_in,
   output logic [pdt_pkg::DIGIT_W-1:0]   digit_out
);

   logic [pdt_pkg::DIGIT_W-1:0] digit_ff;
   logic [pdt_pkg::DIGIT_W-1:0] digit_in;

   always_comb begin
      unique case (mode)
         pdt_pkg::CH_SHIFT1: digit_in = near_in;
         pdt_pkg::CH_SHIFT2: digit_in = far_in;
         pdt_pkg::CH_HOLD:   digit_in = digit_ff;
         default:            digit_in = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit_out = digit_ff;

endmodule

@@ rtl/pdt_chain.sv @@
// row of digit cells: a byte enters as two nibbles at the low end,
// digits leave at the head cell chosen by the field length; uses pdt_pkg, pdt_cell
`timescale 1ns / 1ps
module pdt_chain (
   input  logic                          clock,
   input  pdt_pkg::chain_ctrl_type       ctrl,
   output logic [pdt_pkg::DIGIT_W-1:0]   head_digit
);

   logic [pdt_pkg::DIGIT_W-1:0] link   [pdt_pkg::CHAIN_CELLS+1];
   logic [pdt_pkg::DIGIT_W-1:0] cell_q [pdt_pkg::CHAIN_CELLS];

   // the two places below cell zero carry the incoming byte
   assign link[0] = ctrl.lo;
   assign link[1] = ctrl.hi;

   for (genvar k = 0; k < pdt_pkg::CHAIN_CELLS; k++) begin : g_cell
      pdt_cell u_cell (
         .clock     (clock),
         .mode      (ctrl.mode),
         .near_in   (link[k+1]),
         .far_in    (link[k]),
         .digit_out (cell_q[k])
      );
      // the top cell feeds only the head select
      if (k < pdt_pkg::CHAIN_CELLS - 1) begin : g_link
         assign link[k+2] = cell_q[k];
      end
   end

   assign head_digit = cell_q[ctrl.head_sel];

endmodule

@@ rtl/packed_decimal_to_text.sv @@
// packed decimal to text formatter, top level; uses pdt_pkg, pdt_chain and the
// assertion macros of packed_decimal_to_text_defines.svh
// after the last field byte, the S_START state picks the first emit state, whose character is registered
// one field byte per cycle while loading; no byte is taken again until the field's text is emitted,
//   one character or suppressed leading zero per emit step, plus a start state; emit steps wait on the output
// reset: synchronous, configuration and control registers back to defaults, loading restarts; digit chain not cleared
`timescale 1ns / 1ps
`include "packed_decimal_to_text_defines.svh"
module packed_decimal_to_text (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] field_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] text_char
   output logic [1:0] rsp_tuser,   // [1:0] status
   output logic       rsp_tlast,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int IW = pdt_pkg::DIGIT_IDX_W;
   localparam int FW = pdt_pkg::FB_W;
   localparam int DW = pdt_pkg::DIGIT_W;

   // configuration
   logic [FW-1:0] field_bytes_ff;
   logic [IW-1:0] scale_ff;
   logic          raw_ff;
   logic [7:0]    symbol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_bytes_ff <= FW'(1);
         scale_ff       <= '0;
         raw_ff         <= 1'b0;
         symbol_ff      <= pdt_pkg::SYMBOL_RESET;
      end else if (csr_we) begin
         unique case (pdt_pkg::csr_index_type'(csr_index))
            pdt_pkg::CSR_FIELD_BYTES:    field_bytes_ff <= csr_wdata[FW-1:0];
            pdt_pkg::CSR_SCALE:          scale_ff       <= csr_wdata[IW-1:0];
            pdt_pkg::CSR_RAW_MODE:       raw_ff         <= csr_wdata[0];
            pdt_pkg::CSR_DECIMAL_SYMBOL: symbol_ff      <= csr_wdata;
         endcase
      end
   end

   logic fb_write;
   assign fb_write = csr_we && (pdt_pkg::csr_index_type'(csr_index) == pdt_pkg::CSR_FIELD_BYTES);

   // field geometry
   logic [FW-1:0] eff_fb;
   logic [IW-1:0] n_digits;
   logic [IW-1:0] sc;
   logic [IW-1:0] int_digits;
   logic [IW-1:0] frac_end;
   logic          trim;
   logic          has_frac;

   always_comb begin
      priority if (field_bytes_ff == '0) begin
         eff_fb = FW'(1);
      end else if (field_bytes_ff > FW'(pdt_pkg::MAX_FIELD_BYTES)) begin
         eff_fb = FW'(pdt_pkg::MAX_FIELD_BYTES);
      end else begin
         eff_fb = field_bytes_ff;
      end
   end

   assign n_digits   = IW'({eff_fb, 1'b0} - (FW+1)'(1));
   assign sc         = (scale_ff > n_digits) ? n_digits : scale_ff;
   assign int_digits = n_digits - sc;
   assign trim       = !raw_ff && (sc != '0);

   // load side
   pdt_pkg::state_type state_ff, state_in;
   logic [FW-1:0] bytes_loaded_ff;
   logic          accept;
   logic          first_byte;
   logic          last_byte;
   logic [DW-1:0] in_hi, in_lo;
   logic [pdt_pkg::BYTE_IDX_W-1:0] byte_idx;

   assign req_tready = (state_ff == pdt_pkg::S_LOAD);
   assign accept     = req_tvalid && req_tready;
   assign in_hi      = req_tdata[7:4];
   assign in_lo      = req_tdata[3:0];
   assign first_byte = (bytes_loaded_ff == '0);
   assign last_byte  = ((bytes_loaded_ff + FW'(1)) == eff_fb);
   assign byte_idx   = bytes_loaded_ff[pdt_pkg::BYTE_IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset || fb_write) begin
         bytes_loaded_ff <= '0;
      end else if (accept) begin
         bytes_loaded_ff <= last_byte ? '0 : bytes_loaded_ff + FW'(1);
      end
   end

   // per-field summaries, the first byte starts them over
   logic          bad_ff, bad_in;
   logic          zero_ff, zero_in;
   logic          ebc_ff, ebc_in;
   logic          asc_ff, asc_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [DW-1:0] sign_ff;

   always_comb begin
      bad_in  = (first_byte ? 1'b0 : bad_ff) || (in_hi > pdt_pkg::DIGIT_MAX)
                || (!last_byte && (in_lo > pdt_pkg::DIGIT_MAX));
      zero_in = (first_byte || zero_ff) && (req_tdata == pdt_pkg::BYTE_ZERO);
      ebc_in  = (first_byte || ebc_ff) && (req_tdata == pdt_pkg::BYTE_EBCDIC_BLANK);
      asc_in  = (first_byte || asc_ff) && (req_tdata == pdt_pkg::BYTE_ASCII_BLANK);
      // tail is one past the last nonzero digit, the sign nibble excluded
      priority if (!last_byte && (in_lo != '0)) begin
         tail_in = IW'({byte_idx, 1'b0}) + IW'(2);
      end else if (in_hi != '0) begin
         tail_in = IW'({byte_idx, 1'b1});
      end else begin
         tail_in = first_byte ? '0 : tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bad_ff  <= bad_in;
         zero_ff <= zero_in;
         ebc_ff  <= ebc_in;
         asc_ff  <= asc_in;
         tail_ff <= tail_in;
         sign_ff <= in_lo;
      end
   end

   assign frac_end = trim ? ((tail_ff > int_digits) ? tail_ff : int_digits) : n_digits;
   assign has_frac = (frac_end > int_digits);

   // digit chain
   pdt_pkg::chain_ctrl_type chain_ctrl;
   logic [DW-1:0] head_digit;

   pdt_chain u_chain (
      .clock      (clock),
      .ctrl       (chain_ctrl),
      .head_digit (head_digit)
   );

   // output register
   logic                 rsp_tvalid_ff;
   logic [7:0]           rsp_data_ff;
   pdt_pkg::status_type  rsp_user_ff;
   logic                 rsp_last_ff;
   logic                 emit_ok;

   assign emit_ok = !rsp_tvalid_ff || rsp_tready;

   // emit sequencer
   logic [IW-1:0] pos_ff, pos_in;
   logic          lead_ff, lead_in;
   logic          out_push;
   logic [7:0]    out_char;
   pdt_pkg::status_type out_status;
   logic          out_last;
   logic          negative;
   logic          is_null;
   logic          int_final;
   logic          frac_final;
   logic          skip;
   logic [7:0]    digit_char;

   assign negative   = (sign_ff == pdt_pkg::SIGN_MINUS) || (sign_ff == pdt_pkg::SIGN_MINUS_ALT);
   assign is_null    = zero_ff || ebc_ff || asc_ff;
   assign int_final  = (pos_ff == int_digits - IW'(1));
   assign frac_final = (pos_ff == frac_end - IW'(1));
   assign skip       = lead_ff && !int_final && (head_digit == '0);
   assign digit_char = pdt_pkg::CHAR_ZERO | {4'h0, head_digit};

   always_comb begin
      state_in            = state_ff;
      pos_in              = pos_ff;
      lead_in             = lead_ff;
      out_push            = 1'b0;
      out_char            = '0;
      out_status          = pdt_pkg::STATUS_TEXT;
      out_last            = 1'b0;
      chain_ctrl.mode     = pdt_pkg::CH_HOLD;
      chain_ctrl.hi       = in_hi;
      chain_ctrl.lo       = in_lo;
      chain_ctrl.head_sel = n_digits;
      unique case (state_ff)
         pdt_pkg::S_LOAD: begin
            if (accept) begin
               chain_ctrl.mode = pdt_pkg::CH_SHIFT2;
               if (last_byte) begin
                  state_in = pdt_pkg::S_START;
               end
            end
         end
         pdt_pkg::S_START: begin
            pos_in  = '0;
            lead_in = !raw_ff;
            priority if (bad_ff) begin
               state_in = pdt_pkg::S_STATUS;
            end else if (negative) begin
               state_in = pdt_pkg::S_SIGN;
            end else if (int_digits == '0) begin
               state_in = pdt_pkg::S_ZERO;
            end else begin
               state_in = pdt_pkg::S_INT;
            end
         end
         pdt_pkg::S_STATUS: begin
            if (emit_ok) begin
               out_push   = 1'b1;
               out_status = is_null ? pdt_pkg::STATUS_NULL : pdt_pkg::STATUS_INVALID;
               out_last   = 1'b1;
               state_in   = pdt_pkg::S_LOAD;
            end
         end
         pdt_pkg::S_SIGN: begin
            if (emit_ok) begin
               out_push = 1'b1;
               out_char = pdt_pkg::CHAR_MINUS;
               state_in = (int_digits == '0) ? pdt_pkg::S_ZERO : pdt_pkg::S_INT;
            end
         end
         pdt_pkg::S_ZERO: begin
            if (emit_ok) begin
               out_push = 1'b1;
               out_char = pdt_pkg::CHAR_ZERO;
               out_last = !has_frac;
               state_in = has_frac ? pdt_pkg::S_SYM : pdt_pkg::S_LOAD;
            end
         end
         pdt_pkg::S_INT: begin
            if (emit_ok) begin
               chain_ctrl.mode = pdt_pkg::CH_SHIFT1;
               pos_in          = pos_ff + IW'(1);
               if (!skip) begin
                  out_push = 1'b1;
                  out_char = digit_char;
                  out_last = int_final && !has_frac;
                  lead_in  = 1'b0;
               end
               if (int_final) begin
                  state_in = has_frac ? pdt_pkg::S_SYM : pdt_pkg::S_LOAD;
               end
            end
         end
         pdt_pkg::S_SYM: begin
            if (emit_ok) begin
               out_push = 1'b1;
               out_char = symbol_ff;
               state_in = pdt_pkg::S_FRAC;
            end
         end
         pdt_pkg::S_FRAC: begin
            if (emit_ok) begin
               chain_ctrl.mode = pdt_pkg::CH_SHIFT1;
               pos_in          = pos_ff + IW'(1);
               out_push        = 1'b1;
               out_char        = digit_char;
               out_last        = frac_final;
               if (frac_final) begin
                  state_in = pdt_pkg::S_LOAD;
               end
            end
         end
         default: begin
            state_in = pdt_pkg::S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pdt_pkg::S_LOAD;
         pos_ff   <= '0;
         lead_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         lead_ff  <= lead_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_push) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         rsp_data_ff <= out_char;
         rsp_user_ff <= out_status;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   `PDT_ASSERT(a_count_range, bytes_loaded_ff < eff_fb, "byte count past field length")
   `PDT_ASSERT_IMPL(a_load_idle, state_ff != pdt_pkg::S_LOAD, bytes_loaded_ff == '0, "count not cleared while emitting")
   `PDT_ASSERT_IMPL(a_pos_range, state_ff == pdt_pkg::S_INT || state_ff == pdt_pkg::S_FRAC, pos_ff < n_digits, "digit position past field")
   `PDT_ASSERT_IMPL(a_status_alone, rsp_tvalid_ff && rsp_user_ff != pdt_pkg::STATUS_TEXT, rsp_last_ff && rsp_data_ff == '0, "status result not alone")

endmodule

@@ test/text_checker.sv @@
// output checker for the packed decimal to text formatter testbench
// watches the csr, field byte and text channels, predicts the text and compares; uses pdt_pkg
`timescale 1ns / 1ps
module text_checker
   import pdt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic [1:0] rsp_tuser,
   input  logic       rsp_tlast,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output int         mismatches,
   output int         expected_left
);

   typedef struct packed {
      logic [7:0] ch;
      status_type st;
      logic       last;
   } text_result_type;

   logic [7:0] packed_bytes [MAX_FIELD_BYTES];
   int         bytes_in;
   bit         only_zero;
   bit         only_ebcdic_blank;
   bit         only_ascii_blank;

   logic [4:0] cfg_field_bytes;
   logic [4:0] cfg_scale;
   logic       cfg_raw;
   logic [7:0] cfg_symbol;

   text_result_type expected_text [$];

   initial begin
      mismatches    = 0;
      expected_left = 0;
   end

   function automatic logic [3:0] nibble_at(int i);
      logic [7:0] b;
      b = ((i >> 1) < MAX_FIELD_BYTES) ? packed_bytes[i >> 1] : BYTE_ZERO;
      return (i % 2) ? b[3:0] : b[7:4];
   endfunction

   function automatic void restart_field();
      bytes_in          = 0;
      only_zero         = 1'b1;
      only_ebcdic_blank = 1'b1;
      only_ascii_blank  = 1'b1;
   endfunction

   // text of one complete field, or a single status result on a bad digit
   function automatic void format_field(int fb);
      int         n;
      int         sc;
      int         ints;
      int         start;
      int         frac_end;
      bit         bad;
      logic [3:0] sign;
      logic [7:0] chars [$];
      n    = 2 * fb - 1;
      sc   = (cfg_scale > n) ? n : cfg_scale;
      ints = n - sc;
      bad  = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (nibble_at(i) > DIGIT_MAX) bad = 1'b1;
      end
      if (bad) begin
         expected_text.push_back('{ch: 8'h00,
                                   st: (only_zero || only_ebcdic_blank || only_ascii_blank) ?
                                       STATUS_NULL : STATUS_INVALID,
                                   last: 1'b1});
         return;
      end
      sign = packed_bytes[(fb - 1) % MAX_FIELD_BYTES][3:0];
      if (sign == SIGN_MINUS || sign == SIGN_MINUS_ALT) chars.push_back(CHAR_MINUS);
      start = 0;
      if (ints == 0) begin
         chars.push_back(CHAR_ZERO);
      end else if (!cfg_raw) begin
         // always keep one integer digit
         while (start + 1 < ints && nibble_at(start) == 0) start++;
      end
      for (int i = start; i < ints; i++) chars.push_back(CHAR_ZERO + nibble_at(i));
      frac_end = n;
      if (!cfg_raw && sc != 0) begin
         while (frac_end > ints && nibble_at(frac_end - 1) == 0) frac_end--;
      end
      if (frac_end > ints) begin
         chars.push_back(cfg_symbol);
         for (int i = ints; i < frac_end; i++) chars.push_back(CHAR_ZERO + nibble_at(i));
      end
      foreach (chars[k]) begin
         expected_text.push_back('{ch: chars[k], st: STATUS_TEXT,
                                   last: (k == chars.size() - 1)});
      end
   endfunction

   function automatic void take_byte(logic [7:0] b);
      int fb;
      if (cfg_field_bytes == 0) fb = 1;
      else if (cfg_field_bytes > MAX_FIELD_BYTES) fb = MAX_FIELD_BYTES;
      else fb = cfg_field_bytes;
      if (bytes_in < MAX_FIELD_BYTES) packed_bytes[bytes_in] = b;
      if (b != BYTE_ZERO) only_zero = 1'b0;
      if (b != BYTE_EBCDIC_BLANK) only_ebcdic_blank = 1'b0;
      if (b != BYTE_ASCII_BLANK) only_ascii_blank = 1'b0;
      bytes_in++;
      if (bytes_in >= fb) begin
         format_field(fb);
         restart_field();
      end
   endfunction

   function automatic void note_mismatch(text_result_type want, bit none_waiting);
      mismatches++;
      if (mismatches <= 10) begin
         if (none_waiting)
            $display("unexpected text transfer: char %h status %0d last %b",
                     rsp_tdata, rsp_tuser, rsp_tlast);
         else
            $display("text mismatch: expected char %h status %0d last %b, got char %h status %0d last %b",
                     want.ch, want.st, want.last, rsp_tdata, rsp_tuser, rsp_tlast);
      end
   endfunction

   always @(posedge clock) begin : watch
      text_result_type want;
      if (reset) begin
         cfg_field_bytes = 5'd1;
         cfg_scale       = 5'd0;
         cfg_raw         = 1'b0;
         cfg_symbol      = SYMBOL_RESET;
         for (int i = 0; i < MAX_FIELD_BYTES; i++) packed_bytes[i] = BYTE_ZERO;
         restart_field();
         expected_text.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FIELD_BYTES: begin
                  cfg_field_bytes = csr_wdata[4:0];
                  restart_field();
               end
               CSR_SCALE:          cfg_scale  = csr_wdata[4:0];
               CSR_RAW_MODE:       cfg_raw    = csr_wdata[0];
               CSR_DECIMAL_SYMBOL: cfg_symbol = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) take_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_text.size() == 0) begin
               want = '0;
               note_mismatch(want, 1'b1);
            end else begin
               want = expected_text.pop_front();
               if (rsp_tdata !== want.ch || rsp_tuser !== want.st || rsp_tlast !== want.last)
                  note_mismatch(want, 1'b0);
            end
         end
      end
      expected_left = expected_text.size();
   end

endmodule

@@ test/tb.sv @@
// testbench top for packed_decimal_to_text: clock, reset, field byte stimulus and verdict
// depends on pdt_pkg, the block itself and text_checker
`timescale 1ns / 1ps
module tb;
   import pdt_pkg::*;

   localparam int QUIET_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_ITEMS = 170;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   int mismatches;
   int expected_left;
   int quiet_cycles;
   int sent_bytes;
   bit src_gaps;
   bit sink_gaps;
   bit hold_output;

   packed_decimal_to_text uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   text_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .expected_left (expected_left)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // text sink: random stalls, plus one long hold-off on request
   initial begin : sink
      int stall;
      rsp_tready = 1'b0;
      forever begin
         if (hold_output) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_output = 1'b0;
         end
         stall = sink_gaps ? $urandom_range(0, 9) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_byte(logic [7:0] b);
      int gap;
      gap = src_gaps ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_bytes++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      wait (expected_left == 0);
      repeat (6) @(negedge clock);
   endtask

   task automatic configure(logic [4:0] fb, logic [4:0] sc, logic raw, logic [7:0] sym);
      csr_we    <= 1'b1;
      csr_index <= CSR_FIELD_BYTES;
      csr_wdata <= {3'b000, fb};
      @(negedge clock);
      csr_index <= CSR_SCALE;
      csr_wdata <= {3'b000, sc};
      @(negedge clock);
      csr_index <= CSR_RAW_MODE;
      csr_wdata <= {7'b0000000, raw};
      @(negedge clock);
      csr_index <= CSR_DECIMAL_SYMBOL;
      csr_wdata <= sym;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // mostly well-formed numbers with zero runs at both ends, some bad or blank fields
   task automatic send_field(int fb);
      logic [3:0] nib [2*MAX_FIELD_BYTES];
      logic [7:0] fill;
      int         n;
      int         lead;
      int         trail;
      int         kind;
      n     = 2 * fb - 1;
      kind  = $urandom_range(0, 9);
      lead  = $urandom_range(0, n);
      trail = $urandom_range(0, n);
      for (int k = 0; k < n; k++)
         nib[k] = (k < lead || k >= n - trail) ? 4'd0 : 4'($urandom_range(0, 9));
      case ($urandom_range(0, 5))
         0:       nib[n] = 4'hC;
         1:       nib[n] = SIGN_MINUS;
         2:       nib[n] = SIGN_MINUS_ALT;
         3:       nib[n] = 4'hF;
         default: nib[n] = 4'($urandom_range(0, 15));
      endcase
      if (kind == 7) nib[$urandom_range(0, n - 1)] = 4'($urandom_range(10, 15));
      case ($urandom_range(0, 3))
         0:       fill = BYTE_ZERO;
         1:       fill = BYTE_EBCDIC_BLANK;
         2:       fill = BYTE_ASCII_BLANK;
         default: fill = 8'($urandom_range(0, 255));
      endcase
      for (int k = 0; k < fb; k++) begin
         if (kind == 8) send_byte(fill);
         else if (kind == 9) send_byte(8'($urandom_range(0, 255)));
         else send_byte({nib[2*k], nib[2*k+1]});
      end
   endtask

   task automatic run_phase(logic [4:0] fb, logic [4:0] sc, logic raw, logic [7:0] sym);
      int fb_eff;
      int first;
      settle();
      configure(fb, sc, raw, sym);
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      fb_eff = (fb == 0) ? 1 : (fb > MAX_FIELD_BYTES) ? MAX_FIELD_BYTES : fb;
      first  = sent_bytes;
      while (sent_bytes - first < 16) send_field(fb_eff);
   endtask

   initial begin : stimulus
      int         phase;
      int         random_start;
      logic [4:0] fb;
      logic [4:0] sc;
      int         fb_eff;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      csr_we      = 1'b0;
      csr_index   = CSR_FIELD_BYTES;
      csr_wdata   = 8'h00;
      src_gaps    = 1'b1;
      sink_gaps   = 1'b1;
      hold_output = 1'b0;
      sent_bytes  = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: one digit plus sign
      send_byte(8'h0C);
      send_byte(8'h9D);
      send_byte(8'h5B);
      send_byte(8'hAC);
      send_byte(8'h00);
      send_byte(8'hFF);

      // zero stripping down to a single zero, negative fraction, all nines
      settle();
      configure(5'd3, 5'd2, 1'b0, SYMBOL_RESET);
      send_byte(8'h00); send_byte(8'h00); send_byte(8'h0C);
      send_byte(8'h00); send_byte(8'h10); send_byte(8'h0D);
      send_byte(8'h99); send_byte(8'h99); send_byte(8'h9F);

      // scale above digit count, raw mode, odd symbol
      settle();
      configure(5'd2, 5'd7, 1'b1, 8'hFF);
      send_byte(8'h12); send_byte(8'h3C);
      send_byte(8'h00); send_byte(8'h0B);

      // partial field dropped by a field size write
      send_byte(8'h45);
      settle();
      configure(5'd1, 5'd0, 1'b0, SYMBOL_RESET);
      send_byte(8'h7C);

      random_start = sent_bytes;
      phase = 0;
      while (sent_bytes - random_start < RANDOM_ITEMS) begin
         case (phase)
            0: begin
               hold_output = 1'b1;
               run_phase(5'd16, 5'd31, 1'b0, 8'h2C);
            end
            1: run_phase(5'd31, 5'd0, 1'b1, 8'h00);
            2: run_phase(5'd0, 5'd1, 1'b0, 8'h2E);
            default: begin
               fb = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(1, 4))
                                               : 5'($urandom_range(0, 31));
               fb_eff = (fb == 0) ? 1 : (fb > MAX_FIELD_BYTES) ? MAX_FIELD_BYTES : fb;
               sc = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(0, 2 * fb_eff - 1));
               run_phase(fb, sc, ($urandom_range(0, 3) == 0),
                         ($urandom_range(0, 1) == 0) ? SYMBOL_RESET
                                                     : 8'($urandom_range(0, 255)));
            end
         endcase
         phase++;
      end

      req_tvalid <= 1'b0;
      wait (expected_left == 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_left == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
